### hw/rtl/cwd_pkg.sv
// Shared types and constants of the chunked work dispenser.
package cwd_pkg;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_WORK  = 2'd1,
      KIND_BATCH = 2'd2,
      KIND_FINAL = 2'd3
   } req_kind_type;

   localparam int MAX_ACTIVE     = 15;
   localparam int SHARD_SEL_BITS = 4;
   localparam int CHUNK_BITS     = 32;
   localparam int PORT_IDX_BITS  = 48;
   localparam int WIDE_BITS      = 64;
   localparam int WORKER_BITS    = 11;
   localparam int SLOT_COUNT     = 2;

   localparam logic [WORKER_BITS-1:0] FINALS_MAX    = 11'd1024;
   localparam logic [WORKER_BITS-1:0] WORKERS_RESET = 11'd1;
   localparam logic [3:0]             ACTIVE_RESET  = 4'd1;

   localparam logic CSR_ACTIVE_SHARDS = 1'b0;
   localparam logic CSR_WORKER_COUNT  = 1'b1;

   typedef struct packed {
      req_kind_type              kind;
      logic                      bad;
      logic [SHARD_SEL_BITS-1:0] shard;
      logic [SHARD_SEL_BITS-1:0] in_use;
      logic                      live;
   } work_ctrl_type;

endpackage

### hw/rtl/cwd_if.sv
// Request and response channel interfaces of the chunked work dispenser.
interface cwd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  shard_index;
   logic [47:0] range_first;
   logic [47:0] range_last;
   logic [31:0] chunk_step;

   modport source (output valid, req_type, shard_index, range_first, range_last,
                   chunk_step, input ready);
   modport sink (input valid, req_type, shard_index, range_first, range_last,
                 chunk_step, output ready);
endinterface

interface cwd_rsp_if;
   logic        valid;
   logic        ready;
   logic        granted;
   logic [47:0] chunk_first;
   logic [47:0] chunk_last;
   logic        bad_shard;
   logic [10:0] done_workers;
   logic [31:0] batches_seen;
   logic        search_done;

   modport source (output valid, granted, chunk_first, chunk_last, bad_shard,
                   done_workers, batches_seen, search_done, input ready);
   modport sink (input valid, granted, chunk_first, chunk_last, bad_shard,
                 done_workers, batches_seen, search_done, output ready);
endinterface

### hw/rtl/chunked_work_dispenser.sv
// Top level of the chunked work dispenser: front end, queue, back end and CSRs.
//
// Every request word gives exactly one response word, in order. A start-search word
// loads the first active_shards shard queues (at most SHARD_QUEUES, and never more than
// 15) with range and chunk size; a work request takes the next inclusive range from its
// shard's queue; hit and final hit batches advance the counters. The block sustains one
// word per cycle while responses are taken. An accepted request enters the two-slot queue;
// once it heads the queue, the back end's queue read, chunk add, end compare and
// write-back on register storage complete into the response register. A stalled
// response holds the back end, and the input stalls once the queue holds two words
// behind it. Configuration (active_shards at 0x0, worker_count at 0x4) is to be written
// by the user only while no response is outstanding; the block does not enforce it.
module chunked_work_dispenser
   import cwd_pkg::*;
#(
   parameter int SHARD_QUEUES = 8,
   parameter int INDEX_BITS   = 48
) (
   input  logic        clock,
   input  logic        reset,
   cwd_req_if.sink     req,
   cwd_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ENTRY_BITS = $bits(work_ctrl_type) + 2 * INDEX_BITS + CHUNK_BITS;

   logic [3:0]             active_ff, active_in;
   logic [WORKER_BITS-1:0] workers_ff, workers_in;
   logic                   csr_write;

   logic                  push_valid;
   logic                  push_ready;
   work_ctrl_type         push_ctrl;
   logic [INDEX_BITS-1:0] push_first;
   logic [INDEX_BITS-1:0] push_last;
   logic [CHUNK_BITS-1:0] push_step;
   logic                  pop_valid;
   logic                  pop_ready;
   work_ctrl_type         pop_ctrl;
   logic [INDEX_BITS-1:0] pop_first;
   logic [INDEX_BITS-1:0] pop_last;
   logic [CHUNK_BITS-1:0] pop_step;
   logic [ENTRY_BITS-1:0] push_data;
   logic [ENTRY_BITS-1:0] pop_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      active_in  = active_ff;
      workers_in = workers_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_ACTIVE_SHARDS: active_in  = csr_pwdata[3:0];
            CSR_WORKER_COUNT:  workers_in = csr_pwdata[WORKER_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_ACTIVE_SHARDS: csr_prdata = 32'(active_ff);
         CSR_WORKER_COUNT:  csr_prdata = 32'(workers_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= ACTIVE_RESET;
         workers_ff <= WORKERS_RESET;
      end else begin
         active_ff  <= active_in;
         workers_ff <= workers_in;
      end
   end

   cwd_front #(
      .SHARD_QUEUES (SHARD_QUEUES),
      .INDEX_BITS   (INDEX_BITS)
   ) u_front (
      .req           (req),
      .active_shards (active_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_ctrl     (push_ctrl),
      .push_first    (push_first),
      .push_last     (push_last),
      .push_step     (push_step)
   );

   assign push_data = {push_ctrl, push_first, push_last, push_step};
   assign {pop_ctrl, pop_first, pop_last, pop_step} = pop_data;

   cwd_fifo #(
      .WIDTH (ENTRY_BITS)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   cwd_back #(
      .SHARD_QUEUES (SHARD_QUEUES),
      .INDEX_BITS   (INDEX_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_ctrl     (pop_ctrl),
      .pop_first    (pop_first),
      .pop_last     (pop_last),
      .pop_step     (pop_step),
      .worker_count (workers_ff),
      .rsp          (rsp)
   );

   a_stall_holds_back : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !(pop_valid && pop_ready))
      else $error("back end advanced while a response was stalled");

   a_grant_not_bad : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.granted && rsp.bad_shard))
      else $error("grant given on a bad shard");

   a_grant_order : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.granted && (INDEX_BITS <= PORT_IDX_BITS)) |->
         (rsp.chunk_first <= rsp.chunk_last))
      else $error("granted range is reversed");

   a_finals_cap : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.done_workers <= FINALS_MAX))
      else $error("final batch count above its cap");

endmodule

### hw/rtl/cwd_front.sv
// Front end: accepts request words, classifies them and checks the shard number.
module cwd_front
   import cwd_pkg::*;
#(
   parameter int SHARD_QUEUES = 8,
   parameter int INDEX_BITS   = 48
) (
   cwd_req_if.sink                 req,
   input  logic [3:0]              active_shards,
   output logic                    push_valid,
   input  logic                    push_ready,
   output work_ctrl_type           push_ctrl,
   output logic [INDEX_BITS-1:0]   push_first,
   output logic [INDEX_BITS-1:0]   push_last,
   output logic [CHUNK_BITS-1:0]   push_step
);

   localparam int ACTIVE_LIMIT = (SHARD_QUEUES < MAX_ACTIVE) ? SHARD_QUEUES : MAX_ACTIVE;

   logic [3:0]           in_use;
   logic [WIDE_BITS-1:0] first_wide;
   logic [WIDE_BITS-1:0] last_wide;

   assign req.ready  = push_ready;
   assign push_valid = req.valid;

   always_comb begin
      in_use     = (active_shards > 4'(ACTIVE_LIMIT)) ? 4'(ACTIVE_LIMIT) : active_shards;
      first_wide = WIDE_BITS'(req.range_first);
      last_wide  = WIDE_BITS'(req.range_last);
      push_first = first_wide[INDEX_BITS-1:0];
      push_last  = last_wide[INDEX_BITS-1:0];
      push_step  = req.chunk_step;

      push_ctrl.kind   = req_kind_type'(req.req_type);
      push_ctrl.in_use = in_use;
      push_ctrl.shard  = req.shard_index[SHARD_SEL_BITS-1:0];
      push_ctrl.bad    = (req_kind_type'(req.req_type) == KIND_WORK) &&
                         (req.shard_index >= 8'(in_use));
      push_ctrl.live   = push_first <= push_last;
   end

endmodule

### hw/rtl/cwd_fifo.sv
// Two-slot queue between the front end and the back end.
module cwd_fifo
   import cwd_pkg::*;
#(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int COUNT_BITS = $clog2(SLOT_COUNT + 1);

   logic [WIDTH-1:0]      slot_ff [SLOT_COUNT];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = count_ff != COUNT_BITS'(SLOT_COUNT);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(SLOT_COUNT - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(SLOT_COUNT - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + COUNT_BITS'(push) - COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/cwd_back.sv
// Back end: shard queues, hit counters and the response register.
module cwd_back
   import cwd_pkg::*;
#(
   parameter int SHARD_QUEUES = 8,
   parameter int INDEX_BITS   = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  work_ctrl_type          pop_ctrl,
   input  logic [INDEX_BITS-1:0]  pop_first,
   input  logic [INDEX_BITS-1:0]  pop_last,
   input  logic [CHUNK_BITS-1:0]  pop_step,
   input  logic [WORKER_BITS-1:0] worker_count,
   cwd_rsp_if.source              rsp
);

   localparam int QUEUE_DEPTH = (SHARD_QUEUES < MAX_ACTIVE) ? SHARD_QUEUES : MAX_ACTIVE;
   localparam int QIDX_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SUM_BITS    = ((INDEX_BITS > CHUNK_BITS) ? INDEX_BITS : CHUNK_BITS) + 1;

   logic [INDEX_BITS-1:0]  next_start_ff [QUEUE_DEPTH];
   logic [INDEX_BITS-1:0]  next_start_in [QUEUE_DEPTH];
   logic [INDEX_BITS-1:0]  queue_end_ff  [QUEUE_DEPTH];
   logic [INDEX_BITS-1:0]  queue_end_in  [QUEUE_DEPTH];
   logic [CHUNK_BITS-1:0]  queue_chunk_ff [QUEUE_DEPTH];
   logic [CHUNK_BITS-1:0]  queue_chunk_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] queue_live_ff, queue_live_in;
   logic [WORKER_BITS-1:0] finals_ff, finals_in;
   logic [CHUNK_BITS-1:0]  batch_ff, batch_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      granted_ff, granted_in;
   logic [PORT_IDX_BITS-1:0]  chunk_first_ff, chunk_first_in;
   logic [PORT_IDX_BITS-1:0]  chunk_last_ff, chunk_last_in;
   logic                      bad_ff, bad_in;
   logic [WORKER_BITS-1:0]    done_ff;
   logic [CHUNK_BITS-1:0]     batches_ff;
   logic                      search_done_ff, search_done_in;

   logic                  fire;
   logic [QIDX_BITS-1:0]  sel;
   logic [INDEX_BITS-1:0] cur_start;
   logic [INDEX_BITS-1:0] cur_end;
   logic [SUM_BITS-1:0]   sum;
   logic [SUM_BITS-1:0]   sum_plus;
   logic                  sat;
   logic [INDEX_BITS-1:0] range_end;
   logic                  clip;
   logic [INDEX_BITS-1:0] grant_last;
   logic [WIDE_BITS-1:0]  first_wide;
   logic [WIDE_BITS-1:0]  last_wide;

   assign pop_ready = !rsp_valid_ff || rsp.ready;
   assign fire      = pop_valid && pop_ready;
   assign sel       = pop_ctrl.shard[QIDX_BITS-1:0];

   // chunk arithmetic: saturate the sum, clip to the queue end
   always_comb begin
      cur_start  = next_start_ff[sel];
      cur_end    = queue_end_ff[sel];
      sum        = SUM_BITS'(cur_start) + SUM_BITS'(queue_chunk_ff[sel]);
      sum_plus   = SUM_BITS'(cur_start) + SUM_BITS'(queue_chunk_ff[sel]) + SUM_BITS'(1);
      sat        = |sum[SUM_BITS-1:INDEX_BITS];
      range_end  = sat ? '1 : sum[INDEX_BITS-1:0];
      clip       = range_end >= cur_end;
      grant_last = clip ? cur_end : range_end;
      first_wide = WIDE_BITS'(cur_start);
      last_wide  = WIDE_BITS'(grant_last);
   end

   always_comb begin
      next_start_in  = next_start_ff;
      queue_end_in   = queue_end_ff;
      queue_chunk_in = queue_chunk_ff;
      queue_live_in  = queue_live_ff;
      finals_in      = finals_ff;
      batch_in       = batch_ff;
      granted_in     = 1'b0;
      chunk_first_in = '0;
      chunk_last_in  = '0;
      bad_in         = 1'b0;

      case (pop_ctrl.kind)
         KIND_START: begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (4'(i) < pop_ctrl.in_use) begin
                  next_start_in[i]  = pop_first;
                  queue_end_in[i]   = pop_last;
                  queue_chunk_in[i] = pop_step;
                  queue_live_in[i]  = pop_ctrl.live;
               end
            end
            finals_in = '0;
            batch_in  = '0;
         end
         KIND_WORK: begin
            if (pop_ctrl.bad) begin
               bad_in = 1'b1;
            end else if (queue_live_ff[sel]) begin
               granted_in     = 1'b1;
               chunk_first_in = first_wide[PORT_IDX_BITS-1:0];
               chunk_last_in  = last_wide[PORT_IDX_BITS-1:0];
               if (clip) begin
                  queue_live_in[sel] = 1'b0;
               end else begin
                  next_start_in[sel] = sum_plus[INDEX_BITS-1:0];
               end
            end
         end
         KIND_BATCH, KIND_FINAL: begin
            if (batch_ff != '1) begin
               batch_in = batch_ff + 1'b1;
            end
            if ((pop_ctrl.kind == KIND_FINAL) && (finals_ff < FINALS_MAX)) begin
               finals_in = finals_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase

      search_done_in = finals_in >= worker_count;
      rsp_valid_in   = fire ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_live_ff <= '0;
         finals_ff     <= '0;
         batch_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            queue_live_ff <= queue_live_in;
            finals_ff     <= finals_in;
            batch_ff      <= batch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         next_start_ff  <= next_start_in;
         queue_end_ff   <= queue_end_in;
         queue_chunk_ff <= queue_chunk_in;
         granted_ff     <= granted_in;
         chunk_first_ff <= chunk_first_in;
         chunk_last_ff  <= chunk_last_in;
         bad_ff         <= bad_in;
         done_ff        <= finals_in;
         batches_ff     <= batch_in;
         search_done_ff <= search_done_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.granted      = granted_ff;
   assign rsp.chunk_first  = chunk_first_ff;
   assign rsp.chunk_last   = chunk_last_ff;
   assign rsp.bad_shard    = bad_ff;
   assign rsp.done_workers = done_ff;
   assign rsp.batches_seen = batches_ff;
   assign rsp.search_done  = search_done_ff;

endmodule
